// File: sv/quaternion_to_euler_angles_defines.svh
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: assertion macros
// Concurrent check macros, left empty when the design is synthesized.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`ifndef SYNTHESIS
`define QTE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define QTE_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define QTE_ASSERT(lbl, prop, msg)
`define QTE_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: sv/q2e_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: package
// Widths, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package q2e_pkg;

   localparam int OP_W     = 33;   // atan2 operands, Q.28
   localparam int T_W      = 30;   // clamped asin argument
   localparam int ARG_W    = 57;   // radicand, up to 2^56
   localparam int ROOT_W   = 29;   // root, up to 2^28
   localparam int SQ_STEPS = 29;   // one result bit per stage
   localparam int CX_W     = 36;   // CORDIC vector width
   localparam int Z_W      = 26;   // angle in 1/65536 degree
   localparam int OUT_W    = 17;   // angle in 1/128 degree before saturation
   localparam int TAB_LEN  = 24;
   // Index of the last operand delay stage, aligned with the root.
   localparam int OP_LAST  = 3 + SQ_STEPS;

   localparam logic signed [OP_W-1:0]  HALF_Q28 = OP_W'(34'sd134217728);
   localparam logic signed [34:0]      ONE_T    = 35'sd268435456;
   localparam logic signed [T_W-1:0]   ONE_Q28  = T_W'(35'sd268435456);
   localparam logic [ARG_W-1:0]        ONE_SQ   = ARG_W'(1) << 56;
   localparam logic signed [Z_W-1:0]   DEG180   = Z_W'(32'sd11796480);
   localparam logic signed [OUT_W-1:0] OUT180   = OUT_W'(32'sd23040);
   localparam logic signed [OUT_W-1:0] OUT90    = OUT_W'(32'sd11520);

   localparam logic signed [Z_W-1:0] ATAN_TAB [0:TAB_LEN-1] = '{
      26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
      26'sd117304, 26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334, 26'sd3667,
      26'sd1833, 26'sd917, 26'sd458, 26'sd229, 26'sd115, 26'sd57, 26'sd29,
      26'sd14, 26'sd7, 26'sd4, 26'sd2, 26'sd1, 26'sd0
   };

   typedef struct packed {
      logic signed [OP_W-1:0] roll_num;
      logic signed [OP_W-1:0] roll_den;
      logic signed [OP_W-1:0] yaw_num;
      logic signed [OP_W-1:0] yaw_den;
      logic signed [T_W-1:0]  t;
      logic                   clamped;
   } ops_type;

endpackage

// File: sv/q2e_isqrt.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: pipelined integer square root
// Floor square root of a 57-bit radicand, one result bit per stage.
// ----------------------------------------------------------------------------
module q2e_isqrt (
   input  logic                            clock,
   input  logic                            en,
   input  logic [q2e_pkg::ARG_W-1:0]       arg,
   output logic [q2e_pkg::ROOT_W-1:0]      root
);
   localparam int N = q2e_pkg::SQ_STEPS;

   logic [q2e_pkg::ARG_W-1:0] n_ff [0:N-1];
   logic [q2e_pkg::ARG_W:0]   r_ff [0:N-1];

   for (genvar k = 0; k < N; k++) begin : g_step
      logic [q2e_pkg::ARG_W-1:0] n_prev, n_in;
      logic [q2e_pkg::ARG_W:0]   r_prev, r_in, trial;
      localparam logic [q2e_pkg::ARG_W:0] BIT = (q2e_pkg::ARG_W+1)'(1) << (56 - 2*k);
      if (k == 0) begin : g_first
         assign n_prev = arg;
         assign r_prev = '0;
      end else begin : g_next
         assign n_prev = n_ff[k-1];
         assign r_prev = r_ff[k-1];
      end
      always_comb begin
         trial = r_prev + BIT;
         if ({1'b0, n_prev} >= trial) begin
            n_in = n_prev - q2e_pkg::ARG_W'(trial);
            r_in = (r_prev >> 1) + BIT;
         end else begin
            n_in = n_prev;
            r_in = r_prev >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k] <= n_in;
            r_ff[k] <= r_in;
         end
      end
   end

   assign root = r_ff[N-1][q2e_pkg::ROOT_W-1:0];
endmodule

// File: sv/q2e_cordic.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: pipelined CORDIC atan2
// Vectoring mode, one micro-rotation per stage, angle in 1/65536 degree.
// ----------------------------------------------------------------------------
module q2e_cordic #(
   parameter int STAGES = 16
) (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [q2e_pkg::OP_W-1:0]    num,
   input  logic signed [q2e_pkg::OP_W-1:0]    den,
   output logic signed [q2e_pkg::Z_W-1:0]     angle
);
   logic signed [q2e_pkg::CX_W-1:0] x_ff [0:STAGES];
   logic signed [q2e_pkg::CX_W-1:0] y_ff [0:STAGES];
   logic signed [q2e_pkg::Z_W-1:0]  z_ff [0:STAGES];
   logic                            zero_ff [0:STAGES];

   // Left half-plane vectors are turned by 180 degrees first.
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (num == '0) && (den == '0);
         if (den < 0) begin
            x_ff[0] <= -q2e_pkg::CX_W'(den);
            y_ff[0] <= -q2e_pkg::CX_W'(num);
            z_ff[0] <= (num >= 0) ? q2e_pkg::DEG180 : -q2e_pkg::DEG180;
         end else begin
            x_ff[0] <= q2e_pkg::CX_W'(den);
            y_ff[0] <= q2e_pkg::CX_W'(num);
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_rot
      logic signed [q2e_pkg::CX_W-1:0] xs, ys;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + q2e_pkg::ATAN_TAB[i];
            end else begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - q2e_pkg::ATAN_TAB[i];
            end
         end
      end
   end

   assign angle = zero_ff[STAGES] ? '0 : z_ff[STAGES];
endmodule

// File: sv/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles
// Converts a Q2.14 quaternion to roll, pitch and yaw in 1/128 degree.
// ----------------------------------------------------------------------------
// Usage: a beat on the req_ channel carries one quaternion w, x, y, z in
// signed Q2.14. Each accepted beat yields exactly one beat on the rsp_
// channel with roll, yaw (plus or minus 180 degrees), pitch (plus or minus
// 90 degrees) and a flag that is set when the asin argument was clamped.
// The input is used as given; it is not normalized.
// From acceptance to rsp_valid a beat passes the products, sums and
// squaring registers, the bit-per-stage square root that feeds the pitch
// arctangent, the CORDIC pre-rotation, CORDIC_STAGES micro-rotations and
// the output register. Throughput is one beat per cycle unless rsp_stall
// holds a waiting result; every stage advances together.
// When rsp_stall holds a waiting result, the whole pipeline freezes and
// req_stall rises in the same cycle, so nothing is lost or repeated. Bubbles
// inside the pipeline cost nothing while the output is free.
// Synchronous reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_angles_defines.svh"

module quaternion_to_euler_angles #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_roll_angle,
   output logic signed [14:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_yaw_angle,
   output logic               rsp_pitch_clamped
);
   localparam int PIPE  = q2e_pkg::OP_LAST + 2 + CORDIC_STAGES;
   localparam int OP_W  = q2e_pkg::OP_W;
   localparam int OUT_W = q2e_pkg::OUT_W;

   // The pipeline moves whenever the output register is empty or drained.
   logic en;
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   logic vld_ff [0:PIPE-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE; k++) begin
            vld_ff[k] <= 1'b0;
         end
         rsp_valid <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < PIPE; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         rsp_valid <= vld_ff[PIPE-1];
      end
   end

   // Stage 1: nine of the pairwise products (all but w*w), exact in 32 bits.
   logic signed [31:0] wx_ff, yz_ff, wz_ff, xy_ff, xx_ff, yy_ff, zz_ff, wy_ff, zx_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= req_quat_w * req_quat_x;
         yz_ff <= req_quat_y * req_quat_z;
         wz_ff <= req_quat_w * req_quat_z;
         xy_ff <= req_quat_x * req_quat_y;
         xx_ff <= req_quat_x * req_quat_x;
         yy_ff <= req_quat_y * req_quat_y;
         zz_ff <= req_quat_z * req_quat_z;
         wy_ff <= req_quat_w * req_quat_y;
         zx_ff <= req_quat_z * req_quat_x;
      end
   end

   // Stage 2: atan2 operands and the clamped asin argument.
   q2e_pkg::ops_type   ops_in;
   q2e_pkg::ops_type   op_ff [1:q2e_pkg::OP_LAST];
   logic signed [34:0] t_raw;

   always_comb begin
      ops_in.roll_num = OP_W'(wx_ff) + OP_W'(yz_ff);
      ops_in.roll_den = q2e_pkg::HALF_Q28 - OP_W'(yy_ff) - OP_W'(xx_ff);
      ops_in.yaw_num  = OP_W'(wz_ff) + OP_W'(xy_ff);
      ops_in.yaw_den  = q2e_pkg::HALF_Q28 - OP_W'(yy_ff) - OP_W'(zz_ff);
      t_raw = (35'(wy_ff) - 35'(zx_ff)) <<< 1;
      priority if (t_raw > q2e_pkg::ONE_T) begin
         ops_in.t       = q2e_pkg::ONE_Q28;
         ops_in.clamped = 1'b1;
      end else if (t_raw < -q2e_pkg::ONE_T) begin
         ops_in.t       = -q2e_pkg::ONE_Q28;
         ops_in.clamped = 1'b1;
      end else begin
         ops_in.t       = q2e_pkg::T_W'(t_raw);
         ops_in.clamped = 1'b0;
      end
   end

   // The operands wait in a delay line while the square root runs.
   always_ff @(posedge clock) begin
      if (en) begin
         op_ff[1] <= ops_in;
         for (int k = 2; k <= q2e_pkg::OP_LAST; k++) begin
            op_ff[k] <= op_ff[k-1];
         end
      end
   end

   // Stages 3 and 4: t squared, then the radicand 1 - t*t.
   logic signed [59:0]              tt;
   logic [q2e_pkg::ARG_W-1:0]       tsq_ff, arg_ff;
   logic [q2e_pkg::ROOT_W-1:0]      root;

   assign tt = op_ff[1].t * op_ff[1].t;

   always_ff @(posedge clock) begin
      if (en) begin
         tsq_ff <= tt[q2e_pkg::ARG_W-1:0];
         arg_ff <= q2e_pkg::ONE_SQ - tsq_ff;
      end
   end

   q2e_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .arg   (arg_ff),
      .root  (root)
   );

   // Three arctangent pipelines run side by side.
   q2e_pkg::ops_type             ops_last;
   logic signed [q2e_pkg::Z_W-1:0] roll_z, pitch_z, yaw_z;
   logic                         clamp_ff [q2e_pkg::OP_LAST+1:PIPE-1];

   assign ops_last = op_ff[q2e_pkg::OP_LAST];

   q2e_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
      .clock (clock),
      .en    (en),
      .num   (ops_last.roll_num),
      .den   (ops_last.roll_den),
      .angle (roll_z)
   );

   q2e_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
      .clock (clock),
      .en    (en),
      .num   (OP_W'(ops_last.t)),
      .den   ($signed({4'b0000, root})),
      .angle (pitch_z)
   );

   q2e_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
      .clock (clock),
      .en    (en),
      .num   (ops_last.yaw_num),
      .den   (ops_last.yaw_den),
      .angle (yaw_z)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         clamp_ff[q2e_pkg::OP_LAST+1] <= ops_last.clamped;
         for (int k = q2e_pkg::OP_LAST + 2; k < PIPE; k++) begin
            clamp_ff[k] <= clamp_ff[k-1];
         end
      end
   end

   // Output: round to 1/128 degree and saturate any CORDIC overshoot.
   logic signed [OUT_W-1:0] roll_r, pitch_r, yaw_r;
   logic signed [OUT_W-1:0] roll_s, pitch_s, yaw_s;

   always_comb begin
      roll_r  = OUT_W'((roll_z + 26'sd256) >>> 9);
      pitch_r = OUT_W'((pitch_z + 26'sd256) >>> 9);
      yaw_r   = OUT_W'((yaw_z + 26'sd256) >>> 9);
      roll_s  = (roll_r > q2e_pkg::OUT180) ? q2e_pkg::OUT180 :
                (roll_r < -q2e_pkg::OUT180) ? -q2e_pkg::OUT180 : roll_r;
      pitch_s = (pitch_r > q2e_pkg::OUT90) ? q2e_pkg::OUT90 :
                (pitch_r < -q2e_pkg::OUT90) ? -q2e_pkg::OUT90 : pitch_r;
      yaw_s   = (yaw_r > q2e_pkg::OUT180) ? q2e_pkg::OUT180 :
                (yaw_r < -q2e_pkg::OUT180) ? -q2e_pkg::OUT180 : yaw_r;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_roll_angle    <= roll_s[15:0];
         rsp_pitch_angle   <= pitch_s[14:0];
         rsp_yaw_angle     <= yaw_s[15:0];
         rsp_pitch_clamped <= clamp_ff[PIPE-1];
      end
   end

   `QTE_ASSERT(a_roll_range, rsp_valid |-> (rsp_roll_angle <= 16'sd23040 && rsp_roll_angle >= -16'sd23040), "roll out of range")
   `QTE_ASSERT(a_pitch_range, rsp_valid |-> (rsp_pitch_angle <= 15'sd11520 && rsp_pitch_angle >= -15'sd11520), "pitch out of range")
   `QTE_ASSERT(a_pipe_exit, (vld_ff[PIPE-1] && en) |=> rsp_valid, "result dropped at pipeline exit")
   `QTE_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")
endmodule
